>>> rtl/lzwd_pkg.sv
// Shared types and constants for the LZW block decoder.
// Used by lzwd_dict and lzw_compress_block_decoder_top; depends on nothing.
package lzwd_pkg;

	// Request opcodes on the input channel.
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_PULL = 2'd1;
	localparam logic [1:0] OP_END  = 2'd2;

	// Byte address of the output limit register.
	localparam logic [1:0] REG_LIMIT = 2'd0;

	// Fixed code values of the compress format.
	localparam int unsigned CODE_CLEAR = 256;
	localparam int unsigned CODE_FIRST = 257;
	localparam int unsigned MIN_BITS   = 9;
	localparam int unsigned LIMIT_RESET = 67108864;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BUSY     = 2'd1,
		ST_ERROR    = 2'd2,
		ST_FINISHED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_FIRST       = 3'd0,
		PH_AFTER_CLEAR = 3'd1,
		PH_NORMAL      = 3'd2,
		PH_FINISHED    = 3'd3,
		PH_ERROR       = 3'd4
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOP,
		S_DECODE,
		S_WALK_RD,
		S_WALK_WR,
		S_WALK_END,
		S_COMMIT,
		S_PULL,
		S_RESP
	} seq_t;

	// One result as it leaves the block.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       last;
		status_t    status;
	} resp_t;

endpackage

>>> rtl/lzwd_dict.sv
// Dictionary memories: prefix and suffix of each table entry.
// One write port and one registered read port; uses lzwd_pkg.
module lzwd_dict
	import lzwd_pkg::*;
#(
	parameter int MAX_CODE_BITS = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [MAX_CODE_BITS-1:0] waddr,
	input  logic [MAX_CODE_BITS-1:0] wpre,
	input  logic [7:0]               wsuf,
	input  logic [MAX_CODE_BITS-1:0] raddr,
	output logic [MAX_CODE_BITS-1:0] rpre,
	output logic [7:0]               rsuf
);

	localparam int TBL = 1 << MAX_CODE_BITS;

	logic [MAX_CODE_BITS-1:0] pre_mem [TBL];
	logic [7:0]               suf_mem [TBL];

	// New entries are written as they are added; reads are registered.
	always_ff @(posedge clk) begin
		if (we) begin
			pre_mem[waddr] <= wpre;
			suf_mem[waddr] <= wsuf;
		end
		rpre <= pre_mem[raddr];
		rsuf <= suf_mem[raddr];
	end

endmodule

>>> rtl/lzw_compress_block_decoder_top.sv
// LZW block decoder, top level: sequencer, bit unpacker, string stack.
// A pull goes through accept, stack read and result.
// A push passes accept, the loop and result; each skip step, literal, clear or table code
// adds steps in the loop, and a table code walks its chain one dictionary entry at a time.
// One request is in work at a time; the next is taken once its result is registered.
// arst_n clears all control state; tables are only read after being written.
module lzw_compress_block_decoder_top
	import lzwd_pkg::*;
#(
	parameter int MAX_CODE_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  in_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic        last,
	output logic [1:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int MB   = MAX_CODE_BITS;
	localparam int TBL  = 1 << MB;
	localparam int LVW  = MB + 1;
	localparam int BUFW = MB + 8;
	localparam int CNTW = $clog2(BUFW + 1);
	localparam int WW   = $clog2(MB + 1);
	localparam int GW   = $clog2(8 * MB + 1);

	seq_t                 state_q, state_d;
	phase_t               phase_q, phase_d;
	logic [BUFW-1:0]      buf_q, buf_d;
	logic [CNTW-1:0]      cnt_q, cnt_d;
	logic [WW-1:0]        width_q, width_d;
	logic [MB:0]          next_q, next_d;
	logic [MB-1:0]        prev_q, prev_d;
	logic [7:0]           fchar_q, fchar_d;
	logic [GW-1:0]        grp_q, grp_d;
	logic [GW-1:0]        skip_q, skip_d;
	logic [30:0]          ocount_q, ocount_d;
	logic [30:0]          limit_q;
	logic [LVW-1:0]       level_q, level_d;
	logic [LVW-1:0]       wlvl_q, wlvl_d;
	logic [MB-1:0]        c_q, c_d;
	logic [MB-1:0]        code_q, code_d;
	resp_t                resp_q, resp_d;
	logic                 from_phase_q, from_phase_d;

	logic                 res_valid_q;
	resp_t                out_q;
	logic                 out_free;

	logic                 stk_we;
	logic [MB-1:0]        stk_waddr;
	logic [7:0]           stk_wdata;
	logic [MB-1:0]        stk_raddr;
	logic [7:0]           stk_rdata;
	logic [7:0]           stk_mem [TBL];

	logic                 dict_we;
	logic [MB-1:0]        dict_raddr;
	logic [MB-1:0]        dict_rpre;
	logic [7:0]           dict_rsuf;

	logic [GW:0]          gb;
	logic [GW:0]          gsum;
	logic [GW-1:0]        align_skip;
	logic [CNTW-1:0]      skip_n;
	logic [BUFW-1:0]      code_mask;
	logic [MB:0]          next_inc;
	logic [31:0]          sum_one;
	logic [31:0]          sum_lvl;
	status_t              phase_stat;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_LIMIT) ? {1'b0, limit_q} : 32'd0;

	// Output limit register, written on the access cycle of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 31'(LIMIT_RESET);
		end else if (psel && penable && pwrite && pready && paddr == REG_LIMIT) begin
			limit_q <= pwdata[30:0];
		end
	end

	// Status that the decoder phase reports.
	always_comb begin
		case (phase_q)
			PH_ERROR:    phase_stat = ST_ERROR;
			PH_FINISHED: phase_stat = ST_FINISHED;
			default:     phase_stat = ST_OK;
		endcase
	end

	// Shared arithmetic: group bookkeeping, skip length, code mask, limit sums.
	assign gb         = (GW + 1)'(width_q) << 3;
	assign gsum       = {1'b0, grp_q} + (GW + 1)'(width_q);
	assign align_skip = (grp_q == '0) ? '0 : GW'(gb - {1'b0, grp_q});
	assign skip_n     = ((GW + 1)'(skip_q) < (GW + 1)'(cnt_q)) ? CNTW'(skip_q) : cnt_q;
	assign code_mask  = ~({BUFW{1'b1}} << width_q);
	assign next_inc   = next_q + 1'b1;
	assign sum_one    = {1'b0, ocount_q} + 32'd1;
	assign sum_lvl    = {1'b0, ocount_q} + 32'(wlvl_q);
	assign out_free   = !res_valid_q || !res_stall;

	// Sequencer: next state and datapath updates.
	always_comb begin
		state_d      = state_q;
		phase_d      = phase_q;
		buf_d        = buf_q;
		cnt_d        = cnt_q;
		width_d      = width_q;
		next_d       = next_q;
		prev_d       = prev_q;
		fchar_d      = fchar_q;
		grp_d        = grp_q;
		skip_d       = skip_q;
		ocount_d     = ocount_q;
		level_d      = level_q;
		wlvl_d       = wlvl_q;
		c_d          = c_q;
		code_d       = code_q;
		resp_d       = resp_q;
		from_phase_d = from_phase_q;
		stk_we       = 1'b0;
		stk_waddr    = wlvl_q[MB-1:0];
		stk_wdata    = fchar_q;
		stk_raddr    = MB'(level_q - 1'b1);
		dict_we      = 1'b0;
		dict_raddr   = c_q;
		in_stall     = (state_q != S_IDLE);

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					resp_d       = '{out_byte: 8'd0, out_valid: 1'b0, last: 1'b0,
						status: phase_stat};
					from_phase_d = 1'b0;
					state_d      = S_RESP;
					case (op)
						OP_PUSH: begin
							if (level_q != '0) begin
								resp_d.status = ST_BUSY;
							end else if (phase_q != PH_ERROR && phase_q != PH_FINISHED) begin
								buf_d        = buf_q | (BUFW'(in_byte) << cnt_q);
								cnt_d        = cnt_q + CNTW'(8);
								from_phase_d = 1'b1;
								state_d      = S_LOOP;
							end
						end
						OP_PULL: begin
							if (level_q != '0) begin
								level_d = level_q - 1'b1;
								state_d = S_PULL;
							end
						end
						OP_END: begin
							if (level_q != '0) begin
								resp_d.status = ST_BUSY;
							end else if (phase_q == PH_ERROR || phase_q == PH_FINISHED) begin
								resp_d.status = phase_stat;
							end else if (phase_q == PH_FIRST || skip_q != '0) begin
								phase_d       = PH_ERROR;
								resp_d.status = ST_ERROR;
							end else begin
								phase_d       = PH_FINISHED;
								resp_d.status = ST_FINISHED;
							end
						end
						default: begin
							resp_d.status = phase_stat;
						end
					endcase
				end
			end

			// Pull the next code out of the bit buffer, or skip group padding.
			S_LOOP: begin
				if (phase_q == PH_ERROR || phase_q == PH_FINISHED || level_q != '0) begin
					state_d = S_RESP;
				end else if (skip_q != '0) begin
					if (skip_n == '0) begin
						state_d = S_RESP;
					end else begin
						buf_d  = buf_q >> skip_n;
						cnt_d  = cnt_q - skip_n;
						skip_d = skip_q - GW'(skip_n);
					end
				end else if (cnt_q < CNTW'(width_q)) begin
					state_d = S_RESP;
				end else begin
					code_d  = MB'(buf_q & code_mask);
					buf_d   = buf_q >> width_q;
					cnt_d   = cnt_q - CNTW'(width_q);
					grp_d   = (gsum >= gb) ? GW'(gsum - gb) : GW'(gsum);
					state_d = S_DECODE;
				end
			end

			// Classify the code: literal after start or clear, clear, or table code.
			S_DECODE: begin
				state_d = S_LOOP;
				if (phase_q == PH_FIRST || phase_q == PH_AFTER_CLEAR) begin
					if ((LVW)'(code_q) == (LVW)'(CODE_CLEAR) && phase_q == PH_AFTER_CLEAR) begin
						phase_d = PH_FINISHED;
					end else if ((LVW)'(code_q) >= (LVW)'(CODE_CLEAR)
							|| sum_one > {1'b0, limit_q}) begin
						phase_d = PH_ERROR;
						level_d = '0;
					end else begin
						prev_d    = code_q;
						fchar_d   = code_q[7:0];
						stk_we    = 1'b1;
						stk_waddr = '0;
						stk_wdata = code_q[7:0];
						level_d   = LVW'(1);
						ocount_d  = sum_one[30:0];
						phase_d   = PH_NORMAL;
					end
				end else if ((LVW)'(code_q) == (LVW)'(CODE_CLEAR)) begin
					skip_d  = align_skip;
					grp_d   = '0;
					next_d  = (MB + 1)'(CODE_FIRST);
					width_d = WW'(MIN_BITS);
					phase_d = PH_AFTER_CLEAR;
				end else if ({1'b0, code_q} > next_q) begin
					phase_d = PH_ERROR;
					level_d = '0;
				end else if ({1'b0, code_q} == next_q) begin
					// The string of the previous code plus its own first byte.
					stk_we    = 1'b1;
					stk_waddr = '0;
					stk_wdata = fchar_q;
					wlvl_d    = LVW'(1);
					c_d       = prev_q;
					state_d   = S_WALK_RD;
				end else begin
					wlvl_d  = '0;
					c_d     = code_q;
					state_d = S_WALK_RD;
				end
			end

			// Chain walk: fetch the entry of the current code.
			S_WALK_RD: begin
				if ((LVW)'(c_q) < (LVW)'(CODE_CLEAR)) begin
					state_d = S_WALK_END;
				end else if ({1'b0, c_q} >= next_q || wlvl_q >= LVW'(TBL)) begin
					phase_d = PH_ERROR;
					level_d = '0;
					state_d = S_LOOP;
				end else begin
					state_d = S_WALK_WR;
				end
			end

			// Chain walk: stack the suffix and follow the prefix.
			S_WALK_WR: begin
				stk_we    = 1'b1;
				stk_wdata = dict_rsuf;
				wlvl_d    = wlvl_q + 1'b1;
				c_d       = dict_rpre;
				state_d   = S_WALK_RD;
			end

			// The root literal closes the string and becomes its first byte.
			S_WALK_END: begin
				if (wlvl_q >= LVW'(TBL)) begin
					phase_d = PH_ERROR;
					level_d = '0;
					state_d = S_LOOP;
				end else begin
					fchar_d   = c_q[7:0];
					stk_we    = 1'b1;
					stk_wdata = c_q[7:0];
					wlvl_d    = wlvl_q + 1'b1;
					state_d   = S_COMMIT;
				end
			end

			// Check the output limit, publish the string, add a table entry while the table has room.
			S_COMMIT: begin
				state_d = S_LOOP;
				if (sum_lvl > {1'b0, limit_q}) begin
					phase_d = PH_ERROR;
					level_d = '0;
				end else begin
					ocount_d = sum_lvl[30:0];
					level_d  = wlvl_q;
					if (next_q < (MB + 1)'(TBL)) begin
						dict_we = 1'b1;
						next_d  = next_inc;
						if ((next_inc >> width_q) != '0 && width_q < WW'(MB)) begin
							skip_d  = align_skip;
							grp_d   = '0;
							width_d = width_q + 1'b1;
						end
					end
					prev_d = code_q;
				end
			end

			// Stack read data is back: one decoded byte.
			S_PULL: begin
				resp_d  = '{out_byte: stk_rdata, out_valid: 1'b1,
					last: (level_q == '0), status: ST_OK};
				state_d = S_RESP;
			end

			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer and decoder state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_FIRST;
			buf_q        <= '0;
			cnt_q        <= '0;
			width_q      <= WW'(MIN_BITS);
			next_q       <= (MB + 1)'(CODE_FIRST);
			prev_q       <= '0;
			fchar_q      <= '0;
			grp_q        <= '0;
			skip_q       <= '0;
			ocount_q     <= '0;
			level_q      <= '0;
			wlvl_q       <= '0;
			c_q          <= '0;
			code_q       <= '0;
			from_phase_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			phase_q      <= phase_d;
			buf_q        <= buf_d;
			cnt_q        <= cnt_d;
			width_q      <= width_d;
			next_q       <= next_d;
			prev_q       <= prev_d;
			fchar_q      <= fchar_d;
			grp_q        <= grp_d;
			skip_q       <= skip_d;
			ocount_q     <= ocount_d;
			level_q      <= level_d;
			wlvl_q       <= wlvl_d;
			c_q          <= c_d;
			code_q       <= code_d;
			from_phase_q <= from_phase_d;
		end
	end

	// Pending result payload.
	always_ff @(posedge clk) begin
		resp_q <= resp_d;
	end

	// Output register; a finished result is loaded once the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			if (from_phase_q) begin
				out_q <= '{out_byte: 8'd0, out_valid: 1'b0, last: 1'b0, status: phase_stat};
			end else begin
				out_q <= resp_q;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign out_byte  = out_q.out_byte;
	assign out_valid = out_q.out_valid;
	assign last      = out_q.last;
	assign status    = out_q.status;

	// String stack, filled in reverse and drained by pulls.
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		stk_rdata <= stk_mem[stk_raddr];
	end

	lzwd_dict #(
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) u_dict (
		.clk   (clk),
		.we    (dict_we),
		.waddr (next_q[MB-1:0]),
		.wpre  (prev_q),
		.wsuf  (fchar_q),
		.raddr (dict_raddr),
		.rpre  (dict_rpre),
		.rsuf  (dict_rsuf)
	);

endmodule
